[hdl/accel_offset_cal_shake_level_assert.svh]
// Assertion macros used by the checker of the shake level detector.
`ifndef ACCEL_OFFSET_CAL_SHAKE_LEVEL_ASSERT_SVH
`define ACCEL_OFFSET_CAL_SHAKE_LEVEL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AOC_CHECK_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("shake level check failed");

// The consequent must hold in the cycle after the antecedent.
`define AOC_CHECK_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("shake level check failed");

`endif

[hdl/aoc_pkg.sv]
// Shared constants and types of the shake level detector.
`timescale 1ns / 1ps
`default_nettype none

package aoc_pkg;

   localparam int CAL_LOG2_DEFAULT    = 10;
   localparam int NUM_SENSORS_DEFAULT = 2;
   localparam int ACCEL_W             = 16;
   localparam int THRESH_W            = 54;
   localparam int CSR_IDX_W           = 2;

   localparam logic [CSR_IDX_W-1:0] REG_THRESH_HIGH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_THRESH_MID  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_THRESH_LOW  = 2'd2;

   localparam logic [THRESH_W-1:0] THRESH_HIGH_RESET = 54'd11258999068426;
   localparam logic [THRESH_W-1:0] THRESH_MID_RESET  = 54'd2814749767106;
   localparam logic [THRESH_W-1:0] THRESH_LOW_RESET  = 54'd112589990684;

   localparam logic [1:0] LEVEL_QUIET = 2'd0;
   localparam logic [1:0] LEVEL_LOW   = 2'd1;
   localparam logic [1:0] LEVEL_MID   = 2'd2;
   localparam logic [1:0] LEVEL_HIGH  = 2'd3;

   localparam logic [2:0] ALARM_QUIET   = 3'd0;
   localparam logic [2:0] ALARM_S0_MAX  = 3'd3;
   localparam logic [2:0] ALARM_S1_BASE = 3'd3;
   localparam logic [2:0] ALARM_S1_MIN  = 3'd4;
   localparam logic [2:0] ALARM_S1_MAX  = 3'd6;

   typedef struct packed {
      logic [THRESH_W-1:0] high;
      logic [THRESH_W-1:0] mid;
      logic [THRESH_W-1:0] low;
   } thresh_type;

endpackage

`default_nettype wire

[hdl/aoc_cal.sv]
// Per-sensor offset calibration and offset-free absolute differences.
`timescale 1ns / 1ps
`default_nettype none

module aoc_cal
   import aoc_pkg::*;
#(
   parameter int CAL_LOG2    = CAL_LOG2_DEFAULT,
   parameter int NUM_SENSORS = NUM_SENSORS_DEFAULT,
   localparam int SUM_W      = ACCEL_W + CAL_LOG2 + 1,
   localparam int DIFF_W     = ACCEL_W + CAL_LOG2
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       in_valid,
   output logic                      in_ready,
   input  wire                       in_sensor,
   input  wire signed [ACCEL_W-1:0]  in_x,
   input  wire signed [ACCEL_W-1:0]  in_y,
   input  wire signed [ACCEL_W-1:0]  in_z,
   output logic                      out_valid,
   input  wire                       out_ready,
   output logic                      out_sensor,
   output logic [DIFF_W-1:0]         out_dx,
   output logic [DIFF_W-1:0]         out_dy,
   output logic [DIFF_W-1:0]         out_dz
);

   logic [CAL_LOG2:0]        cnt_ff [NUM_SENSORS];
   logic [CAL_LOG2:0]        cnt_in [NUM_SENSORS];
   logic signed [SUM_W-1:0]  sum_ff [NUM_SENSORS][3];
   logic signed [SUM_W-1:0]  sum_in [NUM_SENSORS][3];
   logic [CAL_LOG2:0]        cnt_cur;
   logic signed [SUM_W-1:0]  sum_cur [3];
   logic signed [ACCEL_W-1:0] smp [3];
   logic signed [SUM_W-1:0]  diff [3];
   logic [DIFF_W-1:0]        dabs_in [3];
   logic [DIFF_W-1:0]        dabs_ff [3];
   logic                     sensor_ff;
   logic                     valid_ff;
   logic                     valid_in;
   logic                     sel_ok;
   logic                     calibrating;
   logic                     fire;

   assign smp[0] = in_x;
   assign smp[1] = in_y;
   assign smp[2] = in_z;

   // Only sensor 0 exists when the block is built for a single sensor.
   assign sel_ok      = (NUM_SENSORS > 1) || !in_sensor;
   assign in_ready    = !valid_ff || out_ready;
   assign fire        = in_valid && in_ready;
   // The count saturates at exactly 2^CAL_LOG2, so its top bit marks the end of calibration.
   assign calibrating = !cnt_cur[CAL_LOG2];

   always_comb begin
      cnt_cur = cnt_ff[0];
      for (int a = 0; a < 3; a++) begin
         sum_cur[a] = sum_ff[0][a];
      end
      for (int g = 0; g < NUM_SENSORS; g++) begin
         if (in_sensor == 1'(g)) begin
            cnt_cur = cnt_ff[g];
            for (int a = 0; a < 3; a++) begin
               sum_cur[a] = sum_ff[g][a];
            end
         end
      end
   end

   always_comb begin
      for (int g = 0; g < NUM_SENSORS; g++) begin
         cnt_in[g] = cnt_ff[g];
         for (int a = 0; a < 3; a++) begin
            sum_in[g][a] = sum_ff[g][a];
         end
         if (fire && sel_ok && calibrating && (in_sensor == 1'(g))) begin
            cnt_in[g] = cnt_ff[g] + 1'b1;
            for (int a = 0; a < 3; a++) begin
               sum_in[g][a] = sum_ff[g][a] + SUM_W'(smp[a]);
            end
         end
      end
   end

   // The difference sample * 2^CAL_LOG2 - sum always fits the sum width.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         diff[a]    = (SUM_W'(smp[a]) <<< CAL_LOG2) - sum_cur[a];
         dabs_in[a] = diff[a][SUM_W-1] ? DIFF_W'(-diff[a]) : DIFF_W'(diff[a]);
      end
   end

   always_comb begin
      if (fire) begin
         valid_in = sel_ok && !calibrating;
      end else begin
         valid_in = valid_ff && !out_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int g = 0; g < NUM_SENSORS; g++) begin
            cnt_ff[g] <= '0;
            for (int a = 0; a < 3; a++) begin
               sum_ff[g][a] <= '0;
            end
         end
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         sensor_ff <= in_sensor;
         dabs_ff   <= dabs_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_sensor = sensor_ff;
   assign out_dx     = dabs_ff[0];
   assign out_dy     = dabs_ff[1];
   assign out_dz     = dabs_ff[2];

endmodule

`default_nettype wire

[hdl/aoc_sq.sv]
// Squares of the three differences and their sum, two pipeline stages.
`timescale 1ns / 1ps
`default_nettype none

module aoc_sq
   import aoc_pkg::*;
#(
   parameter int CAL_LOG2 = CAL_LOG2_DEFAULT,
   localparam int DIFF_W  = ACCEL_W + CAL_LOG2,
   localparam int SQ_W    = 2 * DIFF_W,
   localparam int MAG_W   = SQ_W + 2
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                in_valid,
   output logic               in_ready,
   input  wire                in_sensor,
   input  wire [DIFF_W-1:0]   in_dx,
   input  wire [DIFF_W-1:0]   in_dy,
   input  wire [DIFF_W-1:0]   in_dz,
   output logic               out_valid,
   input  wire                out_ready,
   output logic               out_sensor,
   output logic [MAG_W-1:0]   out_mag
);

   logic [SQ_W-1:0]  sq_in [3];
   logic [SQ_W-1:0]  sq_ff [3];
   logic             sens_a_ff;
   logic             valid_a_ff;
   logic             valid_a_in;
   logic             ready_a;
   logic [MAG_W-1:0] mag_in;
   logic [MAG_W-1:0] mag_ff;
   logic             sens_b_ff;
   logic             valid_b_ff;
   logic             valid_b_in;
   logic             ready_b;

   assign ready_b  = !valid_b_ff || out_ready;
   assign ready_a  = !valid_a_ff || ready_b;
   assign in_ready = ready_a;

   assign sq_in[0] = SQ_W'(in_dx) * SQ_W'(in_dx);
   assign sq_in[1] = SQ_W'(in_dy) * SQ_W'(in_dy);
   assign sq_in[2] = SQ_W'(in_dz) * SQ_W'(in_dz);

   assign mag_in = MAG_W'(sq_ff[0]) + MAG_W'(sq_ff[1]) + MAG_W'(sq_ff[2]);

   assign valid_a_in = ready_a ? in_valid : valid_a_ff;
   assign valid_b_in = ready_b ? valid_a_ff : valid_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         valid_a_ff <= valid_a_in;
         valid_b_ff <= valid_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && ready_a) begin
         sq_ff     <= sq_in;
         sens_a_ff <= in_sensor;
      end
      if (valid_a_ff && ready_b) begin
         mag_ff    <= mag_in;
         sens_b_ff <= sens_a_ff;
      end
   end

   assign out_valid  = valid_b_ff;
   assign out_sensor = sens_b_ff;
   assign out_mag    = mag_ff;

endmodule

`default_nettype wire

[hdl/aoc_cls.sv]
// Threshold comparison, alarm coding and the result register.
`timescale 1ns / 1ps
`default_nettype none

module aoc_cls
   import aoc_pkg::*;
#(
   parameter int CAL_LOG2 = CAL_LOG2_DEFAULT,
   localparam int MAG_W   = 2 * (ACCEL_W + CAL_LOG2) + 2,
   localparam int SHIFT   = 2 * CAL_LOG2 - 20
) (
   input  wire               clock,
   input  wire               reset,
   input  wire thresh_type   thresh,
   input  wire               in_valid,
   output logic              in_ready,
   input  wire               in_sensor,
   input  wire [MAG_W-1:0]   in_mag,
   output logic              out_valid,
   input  wire               out_ready,
   output logic [2:0]        out_code,
   output logic              out_sensor
);

   logic [MAG_W-1:0] high_s;
   logic [MAG_W-1:0] mid_s;
   logic [MAG_W-1:0] low_s;
   logic [1:0]       level;
   logic [2:0]       code_in;
   logic [2:0]       code_ff;
   logic             sensor_ff;
   logic             valid_ff;
   logic             valid_in;

   // Bring the thresholds onto the scale of the squared sum; scaling down floors.
   if (SHIFT >= 0) begin : g_scale_up
      assign high_s = MAG_W'(thresh.high) << SHIFT;
      assign mid_s  = MAG_W'(thresh.mid) << SHIFT;
      assign low_s  = MAG_W'(thresh.low) << SHIFT;
   end else begin : g_scale_down
      localparam int DOWN = -SHIFT;
      assign high_s = MAG_W'(thresh.high >> DOWN);
      assign mid_s  = MAG_W'(thresh.mid >> DOWN);
      assign low_s  = MAG_W'(thresh.low >> DOWN);
   end

   // Tested from the top down, whatever order the thresholds are programmed in.
   always_comb begin
      if (in_mag > high_s) begin
         level = LEVEL_HIGH;
      end else if (in_mag > mid_s) begin
         level = LEVEL_MID;
      end else if (in_mag > low_s) begin
         level = LEVEL_LOW;
      end else begin
         level = LEVEL_QUIET;
      end
   end

   always_comb begin
      if (in_sensor && (level != LEVEL_QUIET)) begin
         code_in = {1'b0, level} + ALARM_S1_BASE;
      end else begin
         code_in = {1'b0, level};
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         code_ff   <= code_in;
         sensor_ff <= in_sensor;
      end
   end

   assign out_valid  = valid_ff;
   assign out_code   = code_ff;
   assign out_sensor = sensor_ff;

endmodule

`default_nettype wire

[hdl/accel_offset_cal_shake_level.sv]
// Top level of the accelerometer offset calibration and shake level detector.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_ready  sensor_select, accel_x, accel_y, accel_z
//   rsp      out        rsp_valid/rsp_ready  alarm_code, sensor_id
//   csr      in         csr_we               csr_index, csr_wdata (threshold writes)
//
// One sample is taken every cycle while req_ready is high; each measured sample passes the
// difference, square, sum and result registers, in that order, before it shows on rsp.
// The first 2^CAL_LOG2 samples of each sensor only update its offset sums and give no result.
// Reset clears the offset sums and calibration counts at once; there is no clearing pass.
// A stalled rsp_ready backs up the pipeline stage by stage; req_ready falls only when
// all four stages hold a result and rsp_ready is low.
`timescale 1ns / 1ps
`default_nettype none

module accel_offset_cal_shake_level
   import aoc_pkg::*;
#(
   parameter int CAL_LOG2    = CAL_LOG2_DEFAULT,
   parameter int NUM_SENSORS = NUM_SENSORS_DEFAULT
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  wire                       req_sensor_select,
   input  wire signed [ACCEL_W-1:0]  req_accel_x,
   input  wire signed [ACCEL_W-1:0]  req_accel_y,
   input  wire signed [ACCEL_W-1:0]  req_accel_z,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output logic [2:0]                rsp_alarm_code,
   output logic                      rsp_sensor_id,
   input  wire                       csr_we,
   input  wire [CSR_IDX_W-1:0]       csr_index,
   input  wire [THRESH_W-1:0]        csr_wdata
);

   localparam int DIFF_W = ACCEL_W + CAL_LOG2;
   localparam int MAG_W  = 2 * DIFF_W + 2;

   thresh_type        thresh_ff;
   thresh_type        thresh_in;

   logic              cal_valid;
   logic              cal_ready;
   logic              cal_sensor;
   logic [DIFF_W-1:0] cal_dx;
   logic [DIFF_W-1:0] cal_dy;
   logic [DIFF_W-1:0] cal_dz;

   logic              sq_valid;
   logic              sq_ready;
   logic              sq_sensor;
   logic [MAG_W-1:0]  sq_mag;

   always_comb begin
      thresh_in = thresh_ff;
      if (csr_we) begin
         case (csr_index)
            REG_THRESH_HIGH: thresh_in.high = csr_wdata;
            REG_THRESH_MID:  thresh_in.mid  = csr_wdata;
            REG_THRESH_LOW:  thresh_in.low  = csr_wdata;
            default:         thresh_in      = thresh_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff.high <= THRESH_HIGH_RESET;
         thresh_ff.mid  <= THRESH_MID_RESET;
         thresh_ff.low  <= THRESH_LOW_RESET;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

   aoc_cal #(
      .CAL_LOG2    (CAL_LOG2),
      .NUM_SENSORS (NUM_SENSORS)
   ) u_cal (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_sensor  (req_sensor_select),
      .in_x       (req_accel_x),
      .in_y       (req_accel_y),
      .in_z       (req_accel_z),
      .out_valid  (cal_valid),
      .out_ready  (cal_ready),
      .out_sensor (cal_sensor),
      .out_dx     (cal_dx),
      .out_dy     (cal_dy),
      .out_dz     (cal_dz)
   );

   aoc_sq #(
      .CAL_LOG2 (CAL_LOG2)
   ) u_sq (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (cal_valid),
      .in_ready   (cal_ready),
      .in_sensor  (cal_sensor),
      .in_dx      (cal_dx),
      .in_dy      (cal_dy),
      .in_dz      (cal_dz),
      .out_valid  (sq_valid),
      .out_ready  (sq_ready),
      .out_sensor (sq_sensor),
      .out_mag    (sq_mag)
   );

   aoc_cls #(
      .CAL_LOG2 (CAL_LOG2)
   ) u_cls (
      .clock      (clock),
      .reset      (reset),
      .thresh     (thresh_ff),
      .in_valid   (sq_valid),
      .in_ready   (sq_ready),
      .in_sensor  (sq_sensor),
      .in_mag     (sq_mag),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_code   (rsp_alarm_code),
      .out_sensor (rsp_sensor_id)
   );

endmodule

`default_nettype wire

[hdl/aoc_chk.sv]
// Port-level checker for the shake level detector, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "accel_offset_cal_shake_level_assert.svh"

module aoc_chk
   import aoc_pkg::*;
(
   input wire       clock,
   input wire       reset,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [2:0] rsp_alarm_code,
   input wire       rsp_sensor_id
);

   logic rsp_stall;
   logic s1_code_ok;

   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign s1_code_ok = (rsp_alarm_code == ALARM_QUIET) ||
                       ((rsp_alarm_code >= ALARM_S1_MIN) && (rsp_alarm_code <= ALARM_S1_MAX));

   // A result that is not taken must stay on the port unchanged.
   `AOC_CHECK_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable({rsp_alarm_code, rsp_sensor_id}))

   // Sensor 0 only ever reports the lower codes.
   `AOC_CHECK_NOW(a_sensor0_code, rsp_valid && !rsp_sensor_id, rsp_alarm_code <= ALARM_S0_MAX)

   // Sensor 1 reports quiet or one of the upper codes.
   `AOC_CHECK_NOW(a_sensor1_code, rsp_valid && rsp_sensor_id, s1_code_ok)

   // Nothing can be ready for transfer straight out of reset.
   `AOC_CHECK_NOW(a_reset_quiet, $past(reset), !rsp_valid)

endmodule

bind accel_offset_cal_shake_level aoc_chk u_aoc_chk (.*);

`default_nettype wire
